// File: rtl/assert_macros.svh
// Assertion macros shared by the capped torus distance RTL.
// Plain text, no dependencies; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition implies a consequence in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Condition implies a consequence a fixed number of cycles later.
`define ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/ctd_pkg.sv
// Types and constants of the capped torus distance block.
// No dependencies; imported by the top level.
package ctd_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned RadW   = 23;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CAP_DIR_X    = 3'd0,
    REG_CAP_DIR_Y    = 3'd1,
    REG_MAJOR_RADIUS = 3'd2,
    REG_TUBE_RADIUS  = 3'd3
  } cfg_reg_t;

  localparam logic signed [CoordW-1:0] CapDirXRst    = 24'sd3547;
  localparam logic signed [CoordW-1:0] CapDirYRst    = 24'sd2048;
  localparam logic        [RadW-1:0]   MajorRadiusRst = 23'd4096;
  localparam logic        [RadW-1:0]   TubeRadiusRst  = 23'd1024;

  localparam logic signed [CoordW-1:0] OutMax = 24'sh7FFFFF;
  localparam logic signed [CoordW-1:0] OutMin = 24'sh800000;

endpackage

// File: rtl/ctd_isqrt.sv
// Pipelined floor square root, one result bit per register stage.
// No dependencies; a side word travels alongside each radicand.
module ctd_isqrt #(
  parameter int unsigned IW = 48,
  parameter int unsigned PW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [IW-1:0]     in_rad,
  input  logic [PW-1:0]     in_side,
  output logic              out_vld,
  output logic [IW/2-1:0]   out_root,
  output logic [PW-1:0]     out_side
);

  localparam int unsigned N  = IW / 2;
  localparam int unsigned RW = N + 3;

  logic          vld_r  [N];
  logic [IW-1:0] rad_r  [N];
  logic [RW-1:0] rem_r  [N];
  logic [N-1:0]  root_r [N];
  logic [PW-1:0] side_r [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic          vld_c;
    logic [IW-1:0] rad_c;
    logic [RW-1:0] rem_c;
    logic [N-1:0]  root_c;
    logic [PW-1:0] side_c;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign vld_c  = in_vld;
      assign rad_c  = in_rad;
      assign rem_c  = '0;
      assign root_c = '0;
      assign side_c = in_side;
    end else begin : g_next
      assign vld_c  = vld_r[s-1];
      assign rad_c  = rad_r[s-1];
      assign rem_c  = rem_r[s-1];
      assign root_c = root_r[s-1];
      assign side_c = side_r[s-1];
    end

    assign rem_sh = {rem_c[RW-3:0], rad_c[IW-1:IW-2]};
    assign trial  = RW'({root_c, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      rad_r[s]  <= {rad_c[IW-3:0], 2'b00};
      rem_r[s]  <= ge ? (rem_sh - trial) : rem_sh;
      root_r[s] <= {root_c[N-2:0], ge};
      side_r[s] <= side_c;
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1];
  assign out_side = side_r[N-1];

endmodule

// File: rtl/capped_torus_distance.sv
// Top level of the capped torus signed distance pipeline.
// Depends on ctd_pkg, ctd_isqrt and assert_macros.svh.
//
// Channel   Ports                               Handshake
// input     in_pos_x, in_pos_y, in_pos_z        start high, busy low
// result    out_distance                        out_valid strobe, one cycle
// config    cfg_wr_en, cfg_index, cfg_wdata     write on cfg_wr_en
//
// A word is accepted every cycle; busy is low except while reset is held.
// Words pass through stages 1 to 3, the length square root, stages 4 and 5, the
// argument square root and the output register; both roots give one bit per stage.
// Synchronous reset empties the pipeline and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
`include "assert_macros.svh"

module capped_torus_distance
  import ctd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] in_pos_x,
  input  logic signed [CoordW-1:0] in_pos_y,
  input  logic signed [CoordW-1:0] in_pos_z,
  output logic                     out_valid,
  output logic signed [CoordW-1:0] out_distance,
  input  logic                     cfg_wr_en,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CoordW-1:0]        cfg_wdata
);

  localparam int unsigned KW   = 50 - FRAC_BITS;
  localparam int unsigned KLW  = 18;
  localparam int unsigned KHW  = KW - KLW;
  localparam int unsigned AW   = RadW + KW + 2;
  localparam int unsigned AUW  = (AW - 1) + ((AW - 1) % 2);
  localparam int unsigned RTW  = AUW / 2;
  localparam int unsigned RSW  = RTW + 2;
  localparam int unsigned SQW  = 48;
  localparam int unsigned ZZW  = 47;
  localparam int unsigned PW1  = 1 + KW + SQW + ZZW;
  localparam int unsigned LAT  = 3 + SQW / 2 + 2 + RTW + 1;

  logic signed [CoordW-1:0] cap_dir_x_r, cap_dir_y_r;
  logic [RadW-1:0]          major_radius_r, tube_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_dir_x_r    <= CapDirXRst;
      cap_dir_y_r    <= CapDirYRst;
      major_radius_r <= MajorRadiusRst;
      tube_radius_r  <= TubeRadiusRst;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAP_DIR_X:    cap_dir_x_r    <= cfg_wdata;
        REG_CAP_DIR_Y:    cap_dir_y_r    <= cfg_wdata;
        REG_MAJOR_RADIUS: major_radius_r <= cfg_wdata[RadW-1:0];
        REG_TUBE_RADIUS:  tube_radius_r  <= cfg_wdata[RadW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = !rst_n;

  // Stage 1: fold x.
  logic                     v1_r;
  logic [CoordW-1:0]        ax_r;
  logic signed [CoordW-1:0] y_r, z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= in_pos_x[CoordW-1] ? CoordW'(-in_pos_x) : CoordW'(in_pos_x);
    y_r  <= in_pos_y;
    z_r  <= in_pos_z;
  end

  // Stage 2: products.
  logic signed [CoordW:0] ax_s;
  logic signed [47:0]     yy_full, zz_full;
  logic                   v2_r;
  logic [ZZW-1:0]         axax_r, yy_r, zz_r;
  logic signed [48:0]     cdy_ax_r, cdx_ax_r;
  logic signed [47:0]     cdx_y_r, cdy_y_r;

  assign ax_s    = $signed({1'b0, ax_r});
  assign yy_full = y_r * y_r;
  assign zz_full = z_r * z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    axax_r   <= ZZW'(ax_r * ax_r);
    yy_r     <= yy_full[ZZW-1:0];
    zz_r     <= zz_full[ZZW-1:0];
    cdy_ax_r <= cap_dir_y_r * ax_s;
    cdx_ax_r <= cap_dir_x_r * ax_s;
    cdx_y_r  <= cap_dir_x_r * y_r;
    cdy_y_r  <= cap_dir_y_r * y_r;
  end

  // Stage 3: sums, cap test and dot form of k.
  logic signed [49:0]   dot;
  logic                 v3_r, sel_r;
  logic signed [KW-1:0] kdot_r;
  logic [SQW-1:0]       sqxy_r;
  logic [ZZW-1:0]       zz3_r;

  assign dot = 50'(cdx_ax_r) + 50'(cdy_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    sel_r  <= (cdy_ax_r > 49'(cdx_y_r));
    kdot_r <= KW'(dot >>> FRAC_BITS);
    sqxy_r <= SQW'(axax_r) + SQW'(yy_r);
    zz3_r  <= zz_r;
  end

  // Length form of k.
  logic                 rt1_vld;
  logic [SQW/2-1:0]     rt1_root;
  logic [PW1-1:0]       rt1_side;

  ctd_isqrt #(.IW(SQW), .PW(PW1)) u_len_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v3_r),
    .in_rad   (sqxy_r),
    .in_side  ({sel_r, kdot_r, sqxy_r, zz3_r}),
    .out_vld  (rt1_vld),
    .out_root (rt1_root),
    .out_side (rt1_side)
  );

  // Stage 4: choose k and form the radius products.
  logic                  sel4;
  logic signed [KW-1:0]  kdot4, k_root, k;
  logic [SQW-1:0]        sqxy4;
  logic [ZZW-1:0]        zz4;
  logic signed [RadW:0]  ra_s;
  logic                  v4_r;
  logic [RadW+KLW-1:0]   p_lo_r;
  logic signed [RadW+KHW:0] p_hi_r;
  logic [SQW:0]          base_r;

  assign {sel4, kdot4, sqxy4, zz4} = rt1_side;
  assign k_root = KW'({1'b0, rt1_root});
  assign k      = sel4 ? kdot4 : k_root;
  assign ra_s   = $signed({1'b0, major_radius_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= rt1_vld;
    end
  end

  always_ff @(posedge clk) begin
    p_lo_r <= major_radius_r * k[KLW-1:0];
    p_hi_r <= ra_s * $signed(k[KW-1:KLW]);
    base_r <= (SQW+1)'(sqxy4) + (SQW+1)'(zz4)
            + (SQW+1)'(major_radius_r * major_radius_r);
  end

  // Stage 5: root argument, clamped at zero.
  logic signed [AW-1:0] arg;
  logic                 v5_r;
  logic [AUW-1:0]       argc_r;

  assign arg = $signed(AW'(base_r)) - (AW'(p_hi_r) <<< (KLW + 1))
             - $signed(AW'({p_lo_r, 1'b0}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    argc_r <= arg[AW-1] ? '0 : AUW'(arg[AW-2:0]);
  end

  logic            rt2_vld;
  logic [RTW-1:0]  rt2_root;
  logic [RadW-1:0] rt2_rb;

  ctd_isqrt #(.IW(AUW), .PW(RadW)) u_arg_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v5_r),
    .in_rad   (argc_r),
    .in_side  (tube_radius_r),
    .out_vld  (rt2_vld),
    .out_root (rt2_root),
    .out_side (rt2_rb)
  );

  // Output stage: subtract the tube radius and saturate.
  logic signed [RSW-1:0] res;

  assign res = $signed(RSW'(rt2_root)) - $signed(RSW'(rt2_rb));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= rt2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res > OutMax) begin
      out_distance <= OutMax;
    end else if (res < OutMin) begin
      out_distance <= OutMin;
    end else begin
      out_distance <= CoordW'(res);
    end
  end

  `ASSERT_DELAY(a_word_delivered, clk, rst_n, start && !busy, LAT, out_valid)
  `ASSERT_IMPLIES(a_no_stray_word, clk, rst_n, out_valid, $past(start && !busy, LAT))
  `ASSERT_NEXT(a_bad_index_ignored, clk, rst_n, cfg_wr_en && cfg_index > REG_TUBE_RADIUS,
    $stable(cap_dir_x_r) && $stable(cap_dir_y_r) && $stable(major_radius_r) && $stable(tube_radius_r))

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the capped torus signed distance block.
// Depends on ctd_pkg and the capped_torus_distance RTL; predicts each
// distance word in fixed point and compares it with the output strobe.
`timescale 1ns / 100ps

module testbench;
  import ctd_pkg::*;

  localparam int unsigned FracBits = 12;
  localparam int unsigned DrainCycles = 100;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CoordW-1:0] in_pos_x = '0;
  logic signed [CoordW-1:0] in_pos_y = '0;
  logic signed [CoordW-1:0] in_pos_z = '0;
  logic out_valid;
  logic signed [CoordW-1:0] out_distance;
  logic cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CoordW-1:0] cfg_wdata = '0;

  point_t pending_points[$];
  logic signed [CoordW-1:0] expected_dist[$];
  int unsigned error_count = 0;
  bit quiet_stretch = 1'b0;

  longint dir_x, dir_y, ring_r, tube_r;

  capped_torus_distance #(.FRAC_BITS(FracBits)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .out_valid(out_valid), .out_distance(out_distance),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint floor_root(longint n);
    longint root, bitv;
    root = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return root;
  endfunction

  function automatic logic signed [CoordW-1:0] torus_distance(point_t p);
    longint x, y, z, ax, k, arg, res, sq_xy;
    x = p.x;
    y = p.y;
    z = p.z;
    ax = (x < 0) ? -x : x;
    sq_xy = ax * ax + y * y;
    if (dir_y * ax > dir_x * y) k = (dir_x * ax + dir_y * y) >>> FracBits;
    else k = floor_root(sq_xy);
    arg = sq_xy + z * z + ring_r * ring_r - 2 * ring_r * k;
    if (arg < 0) arg = 0;
    res = floor_root(arg) - tube_r;
    if (res > 64'sd8388607) res = 64'sd8388607;
    if (res < -64'sd8388608) res = -64'sd8388608;
    return res[CoordW-1:0];
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Driver: one word per accepted cycle, with random gaps.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_dist.push_back(torus_distance({in_pos_x, in_pos_y, in_pos_z}));
    end
    if (!rst_n) begin
      start <= 1'b0;
    end else if ((start && busy)) begin
      start <= 1'b1;
    end else if (pending_points.size() != 0 &&
                 (quiet_stretch || $urandom_range(99) >= 16)) begin
      point_t p;
      p = pending_points.pop_front();
      start <= 1'b1;
      in_pos_x <= p.x;
      in_pos_y <= p.y;
      in_pos_z <= p.z;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_dist.size() == 0) begin
        report_mismatch("unexpected word", out_distance, 0);
      end else begin
        logic signed [CoordW-1:0] want;
        want = expected_dist.pop_front();
        if (out_distance !== want) report_mismatch("distance", out_distance, want);
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CoordW-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_CAP_DIR_X: dir_x = longint'($signed(val));
      REG_CAP_DIR_Y: dir_y = longint'($signed(val));
      REG_MAJOR_RADIUS: ring_r = val[RadW-1:0];
      default: tube_r = val[RadW-1:0];
    endcase
  endtask

  task automatic wait_idle();
    int unsigned n;
    while (pending_points.size() != 0 || start || expected_dist.size() != 0)
      @(posedge clk);
    for (n = 0; n < DrainCycles; n++) @(posedge clk);
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord(int unsigned mode);
    logic signed [CoordW-1:0] v;
    case (mode)
      0: v = CoordW'($urandom);
      1: v = $signed(CoordW'($urandom_range(32767))) - 24'sd16384;
      default: v = $signed(CoordW'($urandom_range(4095))) - 24'sd2048;
    endcase
    return v;
  endfunction

  task automatic queue_random(int unsigned count);
    int unsigned i, m;
    point_t p;
    for (i = 0; i < count; i++) begin
      m = $urandom_range(2);
      p.x = rand_coord(m);
      p.y = rand_coord(m);
      p.z = rand_coord($urandom_range(2));
      pending_points.push_back(p);
    end
  endtask

  initial begin
    int unsigned phase;
    point_t p;
    dir_x = CapDirXRst;
    dir_y = CapDirYRst;
    ring_r = MajorRadiusRst;
    tube_r = TubeRadiusRst;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes, the origin and both branches of k.
    p = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF}; pending_points.push_back(p);
    p = '{24'sh800000, 24'sh800000, 24'sh800000}; pending_points.push_back(p);
    p = '{24'sh800000, 24'sh7FFFFF, 24'sh000000}; pending_points.push_back(p);
    p = '{24'sh000000, 24'sh000000, 24'sh000000}; pending_points.push_back(p);
    p = '{24'sh000DDB, 24'sh000800, 24'sh000000}; pending_points.push_back(p);
    p = '{24'shFFF000, 24'sh000000, 24'sh000000}; pending_points.push_back(p);
    p = '{24'sh000000, 24'sh001000, 24'sh000400}; pending_points.push_back(p);
    p = '{24'sh000000, 24'shFFF000, 24'sh800000}; pending_points.push_back(p);
    p = '{24'sh001000, 24'sh000000, 24'sh7FFFFF}; pending_points.push_back(p);
    p = '{24'sh000001, 24'shFFFFFF, 24'shFFFFFF}; pending_points.push_back(p);
    wait_idle();
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_CAP_DIR_X, 24'h7FFFFF);
          write_reg(REG_CAP_DIR_Y, 24'h800000);
          write_reg(REG_MAJOR_RADIUS, 24'h7FFFFF);
          write_reg(REG_TUBE_RADIUS, 24'h000000);
        end
        1: begin
          write_reg(REG_CAP_DIR_X, 24'h800000);
          write_reg(REG_CAP_DIR_Y, 24'h7FFFFF);
          write_reg(REG_MAJOR_RADIUS, 24'h000000);
          write_reg(REG_TUBE_RADIUS, 24'h7FFFFF);
        end
        2: begin
          write_reg(REG_CAP_DIR_X, 24'h000000);
          write_reg(REG_CAP_DIR_Y, 24'h000000);
          write_reg(REG_MAJOR_RADIUS, 24'h002000);
          write_reg(REG_TUBE_RADIUS, 24'h000200);
        end
        default: begin
          write_reg(REG_CAP_DIR_X, CoordW'($urandom));
          write_reg(REG_CAP_DIR_Y, CoordW'($urandom));
          write_reg(REG_MAJOR_RADIUS, CoordW'($urandom_range(16383)));
          write_reg(REG_TUBE_RADIUS, CoordW'($urandom));
        end
      endcase
      quiet_stretch = (phase == 3);
      queue_random(215);
      wait_idle();
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ctd_pkg.sv
rtl/ctd_isqrt.sv
rtl/capped_torus_distance.sv
dv/testbench.sv
